// ===== sv/cpfa_pkg.sv =====
// Shared codes and field widths for the colored page frame allocator.
package cpfa_pkg;

    localparam int GW     = 7;
    localparam int CFG_W  = 11;
    localparam int CIDX_W = 2;
    localparam int RP_W   = 10;
    localparam int FP_W   = 11;
    localparam int ST_W   = 3;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_ALLOC_RUN = 2'd1,
        CMD_FREE      = 2'd2,
        CMD_REBUILD   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NO_MEM    = 3'd1,
        STAT_BAD_REQ   = 3'd2,
        STAT_BAD_PAGE  = 3'd3,
        STAT_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PG_FREE  = 2'd0,
        PG_SECT  = 2'd1,
        PG_CACHE = 2'd2,
        PG_PERM  = 2'd3
    } pg_state_t;

    typedef enum logic [1:0] {
        CFG_COLOR_MASK = 2'd0,
        CFG_L1_STEP    = 2'd1,
        CFG_RESERVED   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_OWN = 2'd0,
        PH_L1  = 2'd1,
        PH_ALL = 2'd2
    } phase_t;

endpackage

// ===== sv/colored_page_frame_allocator.sv =====
// Colored page frame allocator: per-color free lists kept in synchronous memories.
//
// One item at a time. A free reads the page state and the head of its color list, then
// links the page in if it was allocated; a single allocation reads the head of each color
// list probed, then unlinks the first page found; a rebuild walks every page from the top
// down, listing free pages and marking permanent ones. A contiguous allocation checks each
// page of a candidate run, then for every page of the run walks its color list link by link.
// The page state, link and head memories each have a single synchronous read port. Results
// leave through an output register, so the next item is taken while a result waits.
module colored_page_frame_allocator
    import cpfa_pkg::*;
#(
    parameter int PAGES      = 1024,
    parameter int MAX_COLORS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic              page_use,
    input  logic [19:0]       virt_page,
    input  logic [9:0]        page_number,
    input  logic [10:0]       page_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [RP_W-1:0]   result_page,
    output logic [ST_W-1:0]   status,
    output logic [FP_W-1:0]   free_pages,
    output logic              pages_available
);

    localparam int PW = $clog2(PAGES);
    localparam int CW = $clog2(PAGES + 1);
    localparam int HW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int LUT_N = 1 << GW;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_HREQ = 17'h00002,
        S_HCHK = 17'h00004,
        S_SNGL = 17'h00008,
        S_RUNRD = 17'h00010,
        S_RUNCK = 17'h00020,
        S_NXTC = 17'h00040,
        S_ULH  = 17'h00080,
        S_ULHD = 17'h00100,
        S_ULN  = 17'h00200,
        S_ULW  = 17'h00400,
        S_ULL  = 17'h00800,
        S_FREE = 17'h01000,
        S_RBRD = 17'h02000,
        S_RBWR = 17'h04000,
        S_RBDIV = 17'h08000,
        S_DONE = 17'h10000
    } fsm_t;

    logic [HW-1:0] slot_lut [LUT_N];
    for (genvar gi = 0; gi < LUT_N; gi++) begin : g_slot
        assign slot_lut[gi] = HW'(gi % MAX_COLORS);
    end

    logic [1:0]  ps_mem [PAGES];
    logic [PW:0] nf_mem [PAGES];
    logic [PW:0] hd_mem [MAX_COLORS];

    logic          ps_we, nf_we, hd_we;
    logic [PW-1:0] ps_waddr, ps_raddr, nf_waddr, nf_raddr;
    logic [1:0]    ps_wdata;
    logic [PW:0]   nf_wdata, hd_wdata;
    logic [HW-1:0] hd_waddr, hd_raddr;
    logic [1:0]    ps_rd_reg;
    logic [PW:0]   nf_rd_reg, hd_rd_reg;
    logic          hv_rd_reg;

    logic [GW-1:0]   cmask_reg, cstep_reg;
    logic [CFG_W-1:0] cresv_reg;

    fsm_t          state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic          use_reg, use_next;
    logic [GW-1:0] color_reg, color_next;
    phase_t        phase_reg, phase_next;
    logic [GW-1:0] iter_reg, iter_next;
    logic [PW-1:0] cand_reg, cand_next, q_reg, q_next, prev_reg, prev_next;
    logic [PW-1:0] j_reg, j_next, pg_reg, pg_next, res_reg, res_next;
    logic [CW-1:0] k_reg, k_next, cnt_reg, cnt_next, total_reg, total_next;
    logic [HW-1:0] slot_reg, slot_next;
    logic          flag_reg, flag_next, built_reg, built_next;
    logic [GW-1:0] gmask_reg, gmask_next, gstep_reg, gstep_next;
    logic [GW-1:0] gl1s_reg, gl1s_next, rem_reg, rem_next;
    status_t       stat_reg, stat_next;
    logic [MAX_COLORS-1:0] hv_reg, hv_next;

    logic            out_valid_reg, out_valid_next, out_avail_reg, out_avail_next;
    logic [RP_W-1:0] out_page_reg, out_page_next;
    logic [ST_W-1:0] out_stat_reg, out_stat_next;
    logic [FP_W-1:0] out_free_reg, out_free_next;

    logic [GW-1:0] col_step, col_one, adv_color, adv_iter;
    phase_t        adv_phase;
    logic          adv_end;
    logic [PW:0]   head_rd;
    pg_state_t     st_rd;
    logic [PW-1:0] q_comb;
    logic [GW-1:0] step7, mp1, l2n;

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign result_page     = out_page_reg;
    assign status          = out_stat_reg;
    assign free_pages      = out_free_reg;
    assign pages_available = out_avail_reg;

    assign head_rd = hv_rd_reg ? hd_rd_reg : {1'b1, PW'(0)};
    assign st_rd   = built_reg ? pg_state_t'(ps_rd_reg) : PG_PERM;
    assign q_comb  = cand_reg + PW'(k_reg);

    assign col_step = (color_reg + gstep_reg) & gmask_reg;
    assign col_one  = (color_reg + GW'(1)) & gmask_reg;
    assign step7    = (cstep_reg == '0) ? GW'(1) : cstep_reg;
    assign mp1      = cmask_reg + GW'(1);
    assign l2n      = (mp1 < step7) ? step7 : mp1;

    always_comb
    begin
        adv_end   = 1'b0;
        adv_phase = phase_reg;
        adv_iter  = iter_reg;
        adv_color = color_reg;
        case (phase_reg)
            PH_OWN:
            begin
                adv_phase = PH_L1;
                adv_iter  = '0;
                adv_color = col_step;
            end
            PH_L1:
            begin
                if (iter_reg == gl1s_reg - GW'(1))
                begin
                    adv_phase = PH_ALL;
                    adv_iter  = '0;
                    adv_color = col_one;
                end
                else
                begin
                    adv_iter  = iter_reg + GW'(1);
                    adv_color = col_step;
                end
            end
            default:
            begin
                if (iter_reg == gmask_reg)
                begin
                    adv_end = 1'b1;
                end
                else
                begin
                    adv_iter  = iter_reg + GW'(1);
                    adv_color = col_one;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmask_reg <= '0;
            cstep_reg <= GW'(1);
            cresv_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLOR_MASK: cmask_reg <= GW'(cfg_data[5:0]);
                CFG_L1_STEP:    cstep_reg <= cfg_data[GW-1:0];
                CFG_RESERVED:   cresv_reg <= cfg_data;
                default:        cresv_reg <= cresv_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        use_next   = use_reg;
        color_next = color_reg;
        phase_next = phase_reg;
        iter_next  = iter_reg;
        cand_next  = cand_reg;
        q_next     = q_reg;
        prev_next  = prev_reg;
        j_next     = j_reg;
        pg_next    = pg_reg;
        res_next   = res_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        slot_next  = slot_reg;
        flag_next  = flag_reg;
        built_next = built_reg;
        gmask_next = gmask_reg;
        gstep_next = gstep_reg;
        gl1s_next  = gl1s_reg;
        rem_next   = rem_reg;
        stat_next  = stat_reg;
        hv_next    = hv_reg;
        out_valid_next = out_valid_reg;
        out_page_next  = out_page_reg;
        out_stat_next  = out_stat_reg;
        out_free_next  = out_free_reg;
        out_avail_next = out_avail_reg;
        ps_we = 1'b0;  ps_waddr = '0;  ps_wdata = PG_FREE;  ps_raddr = '0;
        nf_we = 1'b0;  nf_waddr = '0;  nf_wdata = '0;       nf_raddr = '0;
        hd_we = 1'b0;  hd_waddr = '0;  hd_wdata = '0;       hd_raddr = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (rem_reg >= gstep_reg)
        begin
            rem_next  = rem_reg - gstep_reg;
            gl1s_next = gl1s_reg + GW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    use_next   = page_use;
                    res_next   = '0;
                    stat_next  = STAT_OK;
                    color_next = GW'(virt_page) & gmask_reg;
                    phase_next = PH_OWN;
                    iter_next  = '0;
                    cnt_next   = CW'(1);
                    case (cmd_t'(command))
                        CMD_ALLOC:
                        begin
                            state_next = S_HREQ;
                        end
                        CMD_ALLOC_RUN:
                        begin
                            if (page_count == '0 || 32'(page_count) > 32'(PAGES))
                            begin
                                stat_next  = STAT_BAD_REQ;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cnt_next   = CW'(page_count);
                                state_next = S_HREQ;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (32'(page_number) >= 32'(PAGES))
                            begin
                                stat_next  = STAT_BAD_PAGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pg_next    = PW'(page_number);
                                ps_raddr   = PW'(page_number);
                                hd_raddr   = slot_lut[GW'(page_number) & gmask_reg];
                                slot_next  = hd_raddr;
                                state_next = S_FREE;
                            end
                        end
                        default:
                        begin
                            gstep_next = step7;
                            gmask_next = l2n - GW'(1);
                            rem_next   = l2n;
                            gl1s_next  = '0;
                            hv_next    = '0;
                            total_next = '0;
                            built_next = 1'b1;
                            j_next     = PW'(PAGES - 1);
                            state_next = S_RBRD;
                        end
                    endcase
                end
            end
            S_HREQ:
            begin
                hd_raddr   = slot_lut[color_reg];
                slot_next  = hd_raddr;
                state_next = S_HCHK;
            end
            S_HCHK:
            begin
                if (head_rd[PW])
                begin
                    color_next = adv_color;
                    phase_next = adv_phase;
                    iter_next  = adv_iter;
                    state_next = S_HREQ;
                    if (adv_end)
                    begin
                        stat_next  = STAT_NO_MEM;
                        state_next = S_DONE;
                        if (cmd_reg == CMD_ALLOC)
                        begin
                            flag_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    cand_next = head_rd[PW-1:0];
                    k_next    = '0;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        nf_raddr   = head_rd[PW-1:0];
                        state_next = S_SNGL;
                    end
                    else
                    begin
                        state_next = S_RUNRD;
                    end
                end
            end
            S_SNGL:
            begin
                hd_we    = 1'b1;
                hd_waddr = slot_reg;
                hd_wdata = nf_rd_reg;
                hv_next[slot_reg] = 1'b1;
                ps_we    = 1'b1;
                ps_waddr = cand_reg;
                ps_wdata = use_reg ? PG_CACHE : PG_SECT;
                total_next = total_reg - CW'(1);
                res_next   = cand_reg;
                state_next = S_DONE;
            end
            S_RUNRD:
            begin
                if (32'(cand_reg) + 32'(cnt_reg) > 32'(PAGES))
                begin
                    nf_raddr   = cand_reg;
                    state_next = S_NXTC;
                end
                else
                begin
                    ps_raddr   = q_comb;
                    state_next = S_RUNCK;
                end
            end
            S_RUNCK:
            begin
                if (st_rd != PG_FREE)
                begin
                    nf_raddr   = cand_reg;
                    state_next = S_NXTC;
                end
                else if (k_reg == cnt_reg - CW'(1))
                begin
                    res_next   = cand_reg;
                    k_next     = '0;
                    state_next = S_ULH;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_RUNRD;
                end
            end
            S_NXTC:
            begin
                k_next = '0;
                if (nf_rd_reg[PW])
                begin
                    color_next = adv_color;
                    phase_next = adv_phase;
                    iter_next  = adv_iter;
                    state_next = adv_end ? S_DONE : S_HREQ;
                    if (adv_end)
                    begin
                        stat_next = STAT_NO_MEM;
                    end
                end
                else
                begin
                    cand_next  = nf_rd_reg[PW-1:0];
                    state_next = S_RUNRD;
                end
            end
            S_ULH:
            begin
                q_next     = q_comb;
                hd_raddr   = slot_lut[GW'(q_comb) & gmask_reg];
                slot_next  = hd_raddr;
                state_next = S_ULHD;
            end
            S_ULHD:
            begin
                if (head_rd[PW-1:0] == q_reg)
                begin
                    nf_raddr   = q_reg;
                    state_next = S_ULN;
                end
                else
                begin
                    prev_next  = head_rd[PW-1:0];
                    nf_raddr   = head_rd[PW-1:0];
                    state_next = S_ULW;
                end
            end
            S_ULW:
            begin
                if (nf_rd_reg[PW-1:0] == q_reg)
                begin
                    nf_raddr   = q_reg;
                    state_next = S_ULL;
                end
                else
                begin
                    prev_next = nf_rd_reg[PW-1:0];
                    nf_raddr  = nf_rd_reg[PW-1:0];
                end
            end
            S_ULN, S_ULL:
            begin
                if (state_reg == S_ULN)
                begin
                    hd_we    = 1'b1;
                    hd_waddr = slot_reg;
                    hd_wdata = nf_rd_reg;
                    hv_next[slot_reg] = 1'b1;
                end
                else
                begin
                    nf_we    = 1'b1;
                    nf_waddr = prev_reg;
                    nf_wdata = nf_rd_reg;
                end
                ps_we    = 1'b1;
                ps_waddr = q_reg;
                ps_wdata = use_reg ? PG_CACHE : PG_SECT;
                if (k_reg == cnt_reg - CW'(1))
                begin
                    total_next = total_reg - cnt_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_ULH;
                end
            end
            S_FREE:
            begin
                if (st_rd == PG_SECT || st_rd == PG_CACHE)
                begin
                    ps_we    = 1'b1;
                    ps_waddr = pg_reg;
                    ps_wdata = PG_FREE;
                    nf_we    = 1'b1;
                    nf_waddr = pg_reg;
                    nf_wdata = head_rd;
                    hd_we    = 1'b1;
                    hd_waddr = slot_reg;
                    hd_wdata = {1'b0, pg_reg};
                    hv_next[slot_reg] = 1'b1;
                    total_next = total_reg + CW'(1);
                    flag_next  = 1'b1;
                end
                else
                begin
                    stat_next = STAT_NOT_ALLOC;
                end
                state_next = S_DONE;
            end
            S_RBRD:
            begin
                if (j_reg == '0 || 32'(j_reg) < 32'(cresv_reg))
                begin
                    ps_we    = 1'b1;
                    ps_waddr = j_reg;
                    ps_wdata = PG_PERM;
                    if (j_reg == '0)
                    begin
                        state_next = S_RBDIV;
                    end
                    else
                    begin
                        j_next = j_reg - PW'(1);
                    end
                end
                else
                begin
                    hd_raddr   = slot_lut[GW'(j_reg) & gmask_reg];
                    slot_next  = hd_raddr;
                    state_next = S_RBWR;
                end
            end
            S_RBWR:
            begin
                ps_we    = 1'b1;
                ps_waddr = j_reg;
                ps_wdata = PG_FREE;
                nf_we    = 1'b1;
                nf_waddr = j_reg;
                nf_wdata = head_rd;
                hd_we    = 1'b1;
                hd_waddr = slot_reg;
                hd_wdata = {1'b0, j_reg};
                hv_next[slot_reg] = 1'b1;
                total_next = total_reg + CW'(1);
                j_next     = j_reg - PW'(1);
                state_next = S_RBRD;
            end
            S_RBDIV:
            begin
                if (rem_reg < gstep_reg)
                begin
                    flag_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_page_next  = RP_W'(res_reg);
                    out_stat_next  = stat_reg;
                    out_free_next  = FP_W'(total_reg);
                    out_avail_next = flag_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            flag_reg      <= 1'b1;
            built_reg     <= 1'b0;
            gmask_reg     <= '0;
            gstep_reg     <= GW'(1);
            gl1s_reg      <= GW'(1);
            rem_reg       <= '0;
            hv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            flag_reg      <= flag_next;
            built_reg     <= built_next;
            gmask_reg     <= gmask_next;
            gstep_reg     <= gstep_next;
            gl1s_reg      <= gl1s_next;
            rem_reg       <= rem_next;
            hv_reg        <= hv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        use_reg       <= use_next;
        color_reg     <= color_next;
        phase_reg     <= phase_next;
        iter_reg      <= iter_next;
        cand_reg      <= cand_next;
        q_reg         <= q_next;
        prev_reg      <= prev_next;
        j_reg         <= j_next;
        pg_reg        <= pg_next;
        res_reg       <= res_next;
        k_reg         <= k_next;
        cnt_reg       <= cnt_next;
        slot_reg      <= slot_next;
        stat_reg      <= stat_next;
        out_page_reg  <= out_page_next;
        out_stat_reg  <= out_stat_next;
        out_free_reg  <= out_free_next;
        out_avail_reg <= out_avail_next;
    end

    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ps_wdata;
        end
        ps_rd_reg <= ps_mem[ps_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nf_we)
        begin
            nf_mem[nf_waddr] <= nf_wdata;
        end
        nf_rd_reg <= nf_mem[nf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            hd_mem[hd_waddr] <= hd_wdata;
        end
        hd_rd_reg <= hd_mem[hd_raddr];
        hv_rd_reg <= hv_reg[hd_raddr];
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(PAGES))
        else $error("free page count above page total");

    a_unlink_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ULHD |-> (hv_rd_reg && !hd_rd_reg[PW]))
        else $error("unlink found an empty color list");

    a_run_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUNCK || state_reg == S_HCHK) && !head_rd[PW] |-> built_reg)
        else $error("listed page before any rebuild");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted item did not start");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result shown outside completion");

endmodule

// ===== tb/sv/colored_page_frame_allocator_tb.sv =====
// Self-checking testbench for the colored page frame allocator with a built-in list model.
`timescale 1ns / 100ps

module colored_page_frame_allocator_tb;
    import cpfa_pkg::*;

    localparam int NPG = 1024;
    localparam int NCOL = 64;
    localparam int NONE = 32'hFFFF_FFFF;

    typedef struct {
        logic [9:0]  page;
        status_t     stat;
        logic [10:0] freecnt;
        logic        avail;
    } outcome_t;

    typedef struct {
        cmd_t        cmd;
        logic        use_c;
        logic [19:0] virt;
        logic [9:0]  pg;
        logic [10:0] cnt;
        int          known_stat;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] command = '0;
    logic page_use = 0;
    logic [19:0] virt_page = '0;
    logic [9:0] page_number = '0;
    logic [10:0] page_count = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [RP_W-1:0] result_page;
    logic [ST_W-1:0] status;
    logic [FP_W-1:0] free_pages;
    logic pages_available;

    pg_state_t pstate[NPG];
    int unsigned link[NPG];
    int unsigned head[NCOL];
    int unsigned total_free;
    logic avail_flag;
    int unsigned reg_mask, reg_step, reg_resv;
    int unsigned g_mask, g_step, g_l1s;

    outcome_t pending[$];
    int errors = 0;
    int results_seen = 0;
    int idle_in = 0;
    int idle_out = 0;
    int sent = 0;
    int cnt_by_stat[5];

    colored_page_frame_allocator DUT (.*);

    always #10 clk = ~clk;

    initial
    begin
        #2_000_000_000;
        $display("FAIL colored_page_frame_allocator");
        $finish;
    end

    function automatic int unsigned slot(int unsigned c);
        return (c & g_mask) % NCOL;
    endfunction

    function automatic bit run_free(int unsigned p0, int unsigned n);
        if (p0 >= NPG || n > NPG - p0)
            return 0;
        for (int unsigned k = 0; k < n; k++)
            if (pstate[p0 + k] != PG_FREE)
                return 0;
        return 1;
    endfunction

    function automatic int unsigned probe_color(int unsigned c, int unsigned n);
        int unsigned p;
        int unsigned g;
        p = head[slot(c)];
        g = 0;
        while (p < NPG && g <= NPG)
        begin
            if (run_free(p, n))
                return p;
            p = link[p];
            g++;
        end
        return NONE;
    endfunction

    function automatic int unsigned find_frame(int unsigned virt, int unsigned n);
        int unsigned c;
        int unsigned p;
        c = virt & g_mask;
        p = probe_color(c, n);
        if (p != NONE)
            return p;
        for (int unsigned i = 0; i < g_l1s; i++)
        begin
            c = (c + g_step) & g_mask;
            p = probe_color(c, n);
            if (p != NONE)
                return p;
        end
        for (int unsigned i = 0; i <= g_mask; i++)
        begin
            c = (c + 1) & g_mask;
            p = probe_color(c, n);
            if (p != NONE)
                return p;
        end
        return NONE;
    endfunction

    function automatic void detach(int unsigned p);
        int unsigned s;
        int unsigned prv;
        int unsigned cur;
        int unsigned g;
        s = slot(p);
        prv = NONE;
        cur = head[s];
        g = 0;
        while (cur < NPG && g <= NPG)
        begin
            if (cur == p)
            begin
                if (prv == NONE)
                    head[s] = link[cur];
                else
                    link[prv] = link[cur];
                return;
            end
            prv = cur;
            cur = link[cur];
            g++;
        end
    endfunction

    function automatic void relist_all();
        int unsigned l2n;
        int unsigned s;
        g_step = (reg_step == 0) ? 1 : reg_step;
        l2n = reg_mask + 1;
        if (l2n < g_step)
            l2n = g_step;
        g_mask = l2n - 1;
        g_l1s = l2n / g_step;
        foreach (head[i])
            head[i] = NONE;
        total_free = 0;
        for (int j = NPG - 1; j >= 0; j--)
        begin
            if (j == 0 || j < reg_resv)
                pstate[j] = PG_PERM;
            else
            begin
                s = slot(j);
                pstate[j] = PG_FREE;
                link[j] = head[s];
                head[s] = j;
                total_free++;
            end
        end
        avail_flag = 1;
    endfunction

    function automatic outcome_t predict_alloc(cmd_t cmd, logic use_c, logic [19:0] virt,
                                               logic [9:0] pg, logic [10:0] cnt);
        outcome_t r;
        int unsigned p;
        pg_state_t ust;
        int unsigned s;
        ust = use_c ? PG_CACHE : PG_SECT;
        r.page = 0;
        r.stat = STAT_OK;
        case (cmd)
            CMD_ALLOC:
            begin
                p = find_frame(32'(virt), 1);
                if (p == NONE)
                begin
                    r.stat = STAT_NO_MEM;
                    avail_flag = 0;
                end
                else
                begin
                    detach(p);
                    pstate[p] = ust;
                    total_free--;
                    r.page = 10'(p);
                end
            end
            CMD_ALLOC_RUN:
            begin
                if (cnt == 0 || 32'(cnt) > NPG)
                    r.stat = STAT_BAD_REQ;
                else
                begin
                    p = find_frame(32'(virt), 32'(cnt));
                    if (p == NONE)
                        r.stat = STAT_NO_MEM;
                    else
                    begin
                        for (int unsigned k = 0; k < 32'(cnt); k++)
                        begin
                            detach(p + k);
                            pstate[p + k] = ust;
                        end
                        total_free -= 32'(cnt);
                        r.page = 10'(p);
                    end
                end
            end
            CMD_FREE:
            begin
                if (pstate[pg] != PG_SECT && pstate[pg] != PG_CACHE)
                    r.stat = STAT_NOT_ALLOC;
                else
                begin
                    s = slot(32'(pg));
                    pstate[pg] = PG_FREE;
                    link[pg] = head[s];
                    head[s] = 32'(pg);
                    total_free++;
                    avail_flag = 1;
                end
            end
            default:
                relist_all();
        endcase
        r.freecnt = 11'(total_free);
        r.avail = avail_flag;
        return r;
    endfunction

    // receiver: stall and check
    always @(posedge clk)
    begin
        outcome_t e;
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result page=%0d status=%0d", result_page, status);
            end
            else
            begin
                e = pending.pop_front();
                if (e.stat <= STAT_NOT_ALLOC)
                    cnt_by_stat[e.stat]++;
                if (result_page !== e.page || status !== e.stat
                    || free_pages !== e.freecnt || pages_available !== e.avail)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp page=%0d st=%0d free=%0d av=%0d got %0d %0d %0d %0d",
                                 e.page, e.stat, e.freecnt, e.avail,
                                 result_page, status, free_pages, pages_available);
                end
            end
        end
        out_stall <= ($urandom_range(99) < idle_out);
    end

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        case (idx)
            CFG_COLOR_MASK: reg_mask = value & 6'h3F;
            CFG_L1_STEP:    reg_step = value & 7'h7F;
            default:        reg_resv = value & 11'h7FF;
        endcase
    endtask

    task automatic wait_drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4 * NPG) @(posedge clk);
    endtask

    task automatic send(cmd_t cmd, logic use_c, logic [19:0] virt, logic [9:0] pg,
                        logic [10:0] cnt, int known);
        outcome_t e;
        while ($urandom_range(99) < idle_in)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        page_use <= use_c;
        virt_page <= virt;
        page_number <= pg;
        page_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = predict_alloc(cmd, use_c, virt, pg, cnt);
        if (known >= 0 && e.stat != known)
        begin
            errors++;
            if (errors <= 10)
                $display("directed row status %0d, table says %0d", e.stat, known);
        end
        pending.push_back(e);
        sent++;
    endtask

    task automatic random_item();
        int unsigned r;
        cmd_t cmd;
        logic [10:0] cnt;
        r = $urandom_range(99);
        cmd = r < 45 ? CMD_ALLOC : r < 60 ? CMD_ALLOC_RUN : r < 97 ? CMD_FREE : CMD_REBUILD;
        r = $urandom_range(99);
        cnt = r < 80 ? 11'($urandom_range(1, 8)) : r < 90 ? 11'($urandom_range(9, 64)) :
              r < 95 ? 11'($urandom_range(2047)) : 11'd1024;
        send(cmd, 1'($urandom_range(1)), 20'($urandom), 10'($urandom_range(1023)), cnt, -1);
    endtask

    row_t rows[$];

    initial
    begin
        int unsigned phase_mask[4] = '{0, 63, 7, 3};
        int unsigned phase_step[4] = '{64, 1, 2, 0};
        int unsigned phase_resv[4] = '{1024, 0, 100, 1000};
        foreach (pstate[i])
            pstate[i] = PG_PERM;
        foreach (link[i])
            link[i] = 0;
        foreach (head[i])
            head[i] = NONE;
        foreach (cnt_by_stat[i])
            cnt_by_stat[i] = 0;
        total_free = 0;
        avail_flag = 1;
        reg_mask = 0;
        reg_step = 1;
        reg_resv = 1;
        g_mask = 0;
        g_step = 1;
        g_l1s = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset state first, then extremes
        rows = '{
            '{CMD_ALLOC,     0, 20'h0,     10'd0,    11'd1,    STAT_NO_MEM},
            '{CMD_ALLOC_RUN, 0, 20'h0,     10'd0,    11'd0,    STAT_BAD_REQ},
            '{CMD_ALLOC_RUN, 1, 20'hFFFFF, 10'd0,    11'd1025, STAT_BAD_REQ},
            '{CMD_ALLOC_RUN, 1, 20'h0,     10'd0,    11'd2047, STAT_BAD_REQ},
            '{CMD_FREE,      0, 20'h0,     10'd0,    11'd1,    STAT_NOT_ALLOC},
            '{CMD_FREE,      0, 20'h0,     10'd1023, 11'd1,    STAT_NOT_ALLOC},
            '{CMD_REBUILD,   0, 20'h0,     10'd0,    11'd1,    STAT_OK},
            '{CMD_ALLOC,     0, 20'h0,     10'd0,    11'd1,    STAT_OK},
            '{CMD_ALLOC,     1, 20'hFFFFF, 10'd0,    11'd1,    STAT_OK},
            '{CMD_FREE,      0, 20'h0,     10'd0,    11'd1,    STAT_NOT_ALLOC},
            '{CMD_FREE,      0, 20'h0,     10'd1,    11'd1,    -1},
            '{CMD_FREE,      0, 20'h0,     10'd1,    11'd1,    STAT_NOT_ALLOC},
            '{CMD_ALLOC_RUN, 0, 20'h5,     10'd0,    11'd1024, STAT_NO_MEM},
            '{CMD_ALLOC_RUN, 1, 20'h2,     10'd0,    11'd16,   -1},
            '{CMD_ALLOC_RUN, 0, 20'hAAAAA, 10'd0,    11'd1000, -1},
            '{CMD_FREE,      1, 20'h0,     10'd1023, 11'd1,    -1},
            '{CMD_ALLOC,     1, 20'h55555, 10'd0,    11'd1,    -1},
            '{CMD_ALLOC_RUN, 0, 20'h3,     10'd0,    11'd1,    -1},
            '{CMD_FREE,      1, 20'h0,     10'd512,  11'd1,    -1},
            '{CMD_REBUILD,   1, 20'h0,     10'd0,    11'd1,    STAT_OK}
        };
        foreach (rows[i])
            send(rows[i].cmd, rows[i].use_c, rows[i].virt, rows[i].pg, rows[i].cnt,
                 rows[i].known_stat);
        wait_drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_COLOR_MASK, phase_mask[ph]);
            write_reg(CFG_L1_STEP, phase_step[ph]);
            write_reg(CFG_RESERVED, phase_resv[ph]);
            case (ph)
                0: begin idle_in = 0;  idle_out = 0;  end
                1: begin idle_in = 68; idle_out = 0;  end
                2: begin idle_in = 0;  idle_out = 68; end
                default: begin idle_in = 25; idle_out = 25; end
            endcase
            send(CMD_REBUILD, 0, 0, 0, 1, STAT_OK);
            for (int n = 0; n < 220; n++)
            begin
                random_item();
                if (n == 100)
                begin
                    in_valid <= 0;
                    @(posedge clk);
                    while (pending.size() != 0)
                        @(posedge clk);
                end
                // exhaust memory once in the last phase so the failure path is reached
                if (ph == 3 && n == 150)
                    for (int k = 0; k < 30; k++)
                        send(CMD_ALLOC, 1'($urandom_range(1)), 20'($urandom), 0, 1, -1);
            end
            idle_in = 0;
            idle_out = 0;
            wait_drain();
        end

        $display("%0d items sent, %0d results checked over four color geometries", sent,
                 results_seen);
        $display("status mix ok=%0d nomem=%0d badreq=%0d notalloc=%0d", cnt_by_stat[0],
                 cnt_by_stat[1], cnt_by_stat[2], cnt_by_stat[4]);
        if (errors == 0)
            $display("PASS colored_page_frame_allocator");
        else
            $display("FAIL colored_page_frame_allocator");
        $finish;
    end

endmodule
